// ===== sv/tcw_pkg.sv =====
package tcw_pkg;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = COLUMNS * ROWS;

   localparam int CELL_W   = 16;
   localparam int CODE_W   = 8;
   localparam int ADDR_W   = 11;
   localparam int POS_W    = ADDR_W + 1;
   localparam int COL_W    = $clog2(COLUMNS + 8);
   localparam int TAB_SHIFT = 3;

   localparam logic [CODE_W-1:0] CODE_NEWLINE = 8'd10;
   localparam logic [CODE_W-1:0] CODE_TAB     = 8'd9;
   localparam logic [7:0]        TEXT_ATTR    = 8'h07;

   typedef enum logic {
      OP_PUT  = 1'b0,
      OP_READ = 1'b1
   } tcw_op_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SCROLL
   } tcw_state_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [CELL_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } tcw_ram_cmd_type;

   typedef struct packed {
      logic              load;
      logic [ADDR_W-1:0] cursor;
      logic              from_mem;
   } tcw_result_type;

endpackage

// ===== sv/tcw_cell_ram.sv =====
module tcw_cell_ram (
   input  logic                            clock,
   input  tcw_pkg::tcw_ram_cmd_type        cmd,
   output logic [tcw_pkg::CELL_W-1:0]      rd_data
);
   import tcw_pkg::*;

   logic [CELL_W-1:0] mem [CELL_COUNT];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/tcw_ctrl.sv =====
module tcw_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_operation,
   input  logic [tcw_pkg::CODE_W-1:0]      req_char_code,
   input  logic [tcw_pkg::ADDR_W-1:0]      req_cell_index,
   input  logic                            out_free,
   input  logic [tcw_pkg::CELL_W-1:0]      rd_data,
   output tcw_pkg::tcw_ram_cmd_type        ram_cmd,
   output tcw_pkg::tcw_result_type         result
);
   import tcw_pkg::*;

   localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELL_COUNT - 1);
   localparam logic [ADDR_W-1:0] KEEP_COUNT = ADDR_W'(CELL_COUNT - COLUMNS);

   tcw_state_type     state_ff, state_in;
   logic [ADDR_W-1:0] count_ff, count_in;
   logic [ADDR_W-1:0] cursor_ff, cursor_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic              read_hit_ff, read_hit_in;

   logic              accept;
   logic              is_put;
   logic              is_print;
   logic              out_of_range;
   logic              scroll_need;
   logic [POS_W-1:0]  pos_ext;
   logic [POS_W-1:0]  next_pos;
   logic [POS_W-1:0]  tab_pos;
   logic [COL_W-1:0]  col_sum;

   assign accept       = req_valid && req_ready;
   assign is_put       = tcw_op_type'(req_operation) == OP_PUT;
   assign is_print     = is_put && (req_char_code != CODE_NEWLINE)
                         && (req_char_code != CODE_TAB);
   assign out_of_range = req_cell_index >= ADDR_W'(CELL_COUNT);

   always_comb begin
      pos_ext = {1'b0, cursor_ff};
      tab_pos = ((pos_ext >> TAB_SHIFT) + POS_W'(1)) << TAB_SHIFT;
      if (req_char_code == CODE_NEWLINE) begin
         next_pos = pos_ext - POS_W'(col_ff) + POS_W'(COLUMNS);
      end else if (req_char_code == CODE_TAB) begin
         next_pos = tab_pos;
      end else begin
         next_pos = pos_ext + POS_W'(1);
      end
      col_sum = col_ff + COL_W'(next_pos - pos_ext);
      if (req_char_code == CODE_NEWLINE) begin
         col_in = '0;
      end else if (col_sum >= COL_W'(COLUMNS)) begin
         col_in = col_sum - COL_W'(COLUMNS);
      end else begin
         col_in = col_sum;
      end
      scroll_need = next_pos >= POS_W'(CELL_COUNT);
      if (scroll_need) begin
         cursor_in = ADDR_W'(next_pos - POS_W'(COLUMNS));
      end else begin
         cursor_in = ADDR_W'(next_pos);
      end
      read_hit_in = !out_of_range;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (count_ff == LAST_CELL) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (!is_put) begin
                  state_in = ST_READ;
               end else if (scroll_need) begin
                  state_in = ST_SCROLL;
               end
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         ST_SCROLL: begin
            if (count_ff == LAST_CELL) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      ram_cmd   = '0;
      result    = '0;
      count_in  = count_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_addr = count_ff;
            count_in        = count_ff + ADDR_W'(1);
         end
         ST_IDLE: begin
            req_ready = out_free;
            if (accept && is_print) begin
               ram_cmd.wr_en   = 1'b1;
               ram_cmd.wr_addr = cursor_ff;
               ram_cmd.wr_data = {TEXT_ATTR, req_char_code};
            end
            if (accept && !is_put && !out_of_range) begin
               ram_cmd.rd_en   = 1'b1;
               ram_cmd.rd_addr = req_cell_index;
            end
            if (accept && is_put && scroll_need) begin
               ram_cmd.rd_en   = 1'b1;
               ram_cmd.rd_addr = ADDR_W'(COLUMNS);
               count_in        = '0;
            end
            result.load   = accept && is_put && !scroll_need;
            result.cursor = cursor_in;
         end
         ST_READ: begin
            result.load     = 1'b1;
            result.cursor   = cursor_ff;
            result.from_mem = read_hit_ff;
         end
         ST_SCROLL: begin
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_addr = count_ff;
            if (count_ff < KEEP_COUNT) begin
               ram_cmd.wr_data = rd_data;
            end
            if (count_ff < KEEP_COUNT - ADDR_W'(1)) begin
               ram_cmd.rd_en   = 1'b1;
               ram_cmd.rd_addr = count_ff + ADDR_W'(COLUMNS + 1);
            end
            result.load   = count_ff == LAST_CELL;
            result.cursor = cursor_ff;
            count_in      = count_ff + ADDR_W'(1);
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         count_ff    <= '0;
         cursor_ff   <= '0;
         col_ff      <= '0;
         read_hit_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (accept && is_put) begin
            cursor_ff <= cursor_in;
            col_ff    <= col_in;
         end
         if (accept) begin
            read_hit_ff <= read_hit_in;
         end
      end
   end

endmodule

// ===== sv/text_console_char_writer.sv =====
// Results: a put's is registered in the cycle after acceptance, a read's after ST_READ.
// A put that runs off the last row scrolls the screen; ST_SCROLL rewrites all 2000 cells first.
// Throughput: one put per cycle unless rsp_ready or a scroll stalls; ST_READ takes no new word.
// After reset, a clearing pass writes zero to all 2000 cells, during which no word is accepted.
// Reset is synchronous and active high; the cursor returns to cell zero.
module text_console_char_writer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_operation,
   input  logic [tcw_pkg::CODE_W-1:0]      req_char_code,
   input  logic [tcw_pkg::ADDR_W-1:0]      req_cell_index,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [tcw_pkg::ADDR_W-1:0]      rsp_cursor_position,
   output logic [tcw_pkg::CELL_W-1:0]      rsp_cell_value
);
   import tcw_pkg::*;

   tcw_ram_cmd_type   ram_cmd;
   tcw_result_type    result;
   logic [CELL_W-1:0] rd_data;
   logic              out_free;

   logic              rsp_valid_ff;
   logic [ADDR_W-1:0] rsp_cursor_ff;
   logic [CELL_W-1:0] rsp_value_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   tcw_cell_ram u_ram (
      .clock   (clock),
      .cmd     (ram_cmd),
      .rd_data (rd_data)
   );

   tcw_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_char_code  (req_char_code),
      .req_cell_index (req_cell_index),
      .out_free       (out_free),
      .rd_data        (rd_data),
      .ram_cmd        (ram_cmd),
      .result         (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result.load) begin
         rsp_cursor_ff <= result.cursor;
         rsp_value_ff  <= result.from_mem ? rd_data : '0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_position = rsp_cursor_ff;
   assign rsp_cell_value      = rsp_value_ff;

endmodule

// ===== tb/tb_text_console_char_writer.sv =====
`timescale 1ns / 100ps

module tb_text_console_char_writer;
   import tcw_pkg::*;

   localparam int TAB_STEP    = 8;
   localparam int CYCLE_LIMIT = 12000000;
   localparam int PHASE_WORDS = 400;

   typedef struct {
      logic [ADDR_W-1:0] cursor_position;
      logic [CELL_W-1:0] cell_value;
   } cursor_cell_type;

   class console_scoreboard;
      logic [CELL_W-1:0] screen [CELL_COUNT];
      int unsigned       cursor;
      cursor_cell_type   pending_cursor_cells [$];
      int                errors;

      function new();
         foreach (screen[i]) screen[i] = '0;
         cursor = 0;
         errors = 0;
      endfunction

      function void note_word(tcw_op_type op, logic [CODE_W-1:0] code,
                              logic [ADDR_W-1:0] idx);
         cursor_cell_type expected;
         int unsigned     pos;
         expected.cell_value = '0;
         if (op == OP_READ) begin
            if (idx < CELL_COUNT) expected.cell_value = screen[idx];
         end else begin
            pos = cursor;
            if (pos >= CELL_COUNT) pos = 0;
            if (code == CODE_NEWLINE) begin
               pos = (pos / COLUMNS + 1) * COLUMNS;
            end else if (code == CODE_TAB) begin
               pos = (pos / TAB_STEP + 1) * TAB_STEP;
            end else begin
               screen[pos] = {TEXT_ATTR, code};
               pos++;
            end
            if (pos >= CELL_COUNT) begin
               for (int i = 0; i < CELL_COUNT; i++) begin
                  if (i + COLUMNS < CELL_COUNT) screen[i] = screen[i + COLUMNS];
                  else screen[i] = '0;
               end
               pos -= COLUMNS;
            end
            cursor = pos;
         end
         expected.cursor_position = ADDR_W'(cursor);
         pending_cursor_cells.push_back(expected);
      endfunction

      function void check_word(logic [ADDR_W-1:0] cursor_position,
                               logic [CELL_W-1:0] cell_value);
         cursor_cell_type expected;
         if (pending_cursor_cells.size() == 0) begin
            $error("unexpected result word: cursor_position %0d, cell_value 0x%04h",
                   cursor_position, cell_value);
            errors++;
            return;
         end
         expected = pending_cursor_cells.pop_front();
         if (cursor_position !== expected.cursor_position) begin
            $error("cursor_position: expected %0d, actual %0d",
                   expected.cursor_position, cursor_position);
            errors++;
         end
         if (cell_value !== expected.cell_value) begin
            $error("cell_value: expected 0x%04h, actual 0x%04h",
                   expected.cell_value, cell_value);
            errors++;
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_operation = 1'b0;
   logic [CODE_W-1:0] req_char_code = '0;
   logic [ADDR_W-1:0] req_cell_index = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [ADDR_W-1:0] rsp_cursor_position;
   logic [CELL_W-1:0] rsp_cell_value;

   console_scoreboard sb = new();
   int                send_idle_pct = 0;
   int                recv_stall_pct = 0;
   int                words_sent = 0;
   int                cycle_count = 0;

   text_console_char_writer dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_char_code       (req_char_code),
      .req_cell_index      (req_cell_index),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_cell_value      (rsp_cell_value)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         sb.note_word(tcw_op_type'(req_operation), req_char_code, req_cell_index);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_word(rsp_cursor_position, rsp_cell_value);
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
   end

   task automatic send_word(input tcw_op_type op, input logic [CODE_W-1:0] code,
                            input logic [ADDR_W-1:0] idx);
      int gap;
      gap = 0;
      while (gap < 30 && $urandom_range(99, 0) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_char_code  <= code;
      req_cell_index <= idx;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      words_sent++;
   endtask

   task automatic put_char(input logic [CODE_W-1:0] code);
      send_word(OP_PUT, code, ADDR_W'($urandom_range(2047, 0)));
   endtask

   task automatic read_cell(input int idx);
      send_word(OP_READ, CODE_W'($urandom_range(255, 0)), ADDR_W'(idx));
   endtask

   // Drives the cursor into the last row, scrolls by a newline, tabs or characters, then reads back.
   task automatic scroll_from_last_row(input int mode);
      int prior;
      while (sb.cursor < CELL_COUNT - COLUMNS) put_char(CODE_NEWLINE);
      repeat ($urandom_range(5, 0)) put_char(CODE_W'($urandom_range(126, 32)));
      case (mode)
         0: begin
            put_char(CODE_NEWLINE);
         end
         1: begin
            do begin
               prior = sb.cursor;
               put_char(CODE_TAB);
            end while (sb.cursor > prior);
         end
         default: begin
            do begin
               prior = sb.cursor;
               put_char(CODE_W'($urandom_range(255, 11)));
            end while (sb.cursor > prior);
         end
      endcase
      repeat ($urandom_range(6, 2))
         read_cell($urandom_range(CELL_COUNT - 1, CELL_COUNT - 2 * COLUMNS));
   endtask

   task automatic random_sequence();
      int kind;
      int line_start;
      int pick;
      kind = $urandom_range(99, 0);
      if (kind < 35) begin
         repeat ($urandom_range(24, 8)) begin
            pick = $urandom_range(99, 0);
            if (pick < 40) begin
               pick = $urandom_range(99, 0);
               if (pick < 60) read_cell($urandom_range(CELL_COUNT - 1, 0));
               else if (pick < 85)
                  read_cell((sb.cursor / COLUMNS) * COLUMNS + $urandom_range(COLUMNS - 1, 0));
               else read_cell($urandom_range(2047, CELL_COUNT));
            end else begin
               pick = $urandom_range(99, 0);
               if (pick < 15) put_char(CODE_NEWLINE);
               else if (pick < 25) put_char(CODE_TAB);
               else put_char(CODE_W'($urandom_range(255, 0)));
            end
         end
      end else if (kind < 65) begin
         line_start = sb.cursor;
         repeat ($urandom_range(60, 5)) begin
            if ($urandom_range(9, 0) == 0) put_char(CODE_W'($urandom_range(255, 0)));
            else put_char(CODE_W'($urandom_range(126, 32)));
         end
         put_char(CODE_NEWLINE);
         repeat ($urandom_range(8, 2))
            read_cell((line_start + $urandom_range(70, 0)) % CELL_COUNT);
      end else if (kind < 80) begin
         scroll_from_last_row($urandom_range(2, 0));
      end else begin
         repeat ($urandom_range(20, 6)) begin
            pick = $urandom_range(99, 0);
            if (pick < 35) put_char(CODE_TAB);
            else if (pick < 55) put_char(CODE_NEWLINE);
            else if (pick < 80) put_char(CODE_W'($urandom_range(255, 0)));
            else read_cell($urandom_range(2047, 0));
         end
      end
   endtask

   initial begin
      int target;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      read_cell(0);
      read_cell(CELL_COUNT - 1);
      read_cell(CELL_COUNT);
      read_cell(2047);
      put_char(8'h00);
      put_char(8'hFF);
      put_char(8'h41);
      read_cell(0);
      read_cell(1);
      put_char(CODE_TAB);
      put_char(CODE_TAB);
      put_char(CODE_NEWLINE);
      put_char(8'h80);
      put_char(CODE_NEWLINE);
      send_word(OP_READ, 8'hFF, ADDR_W'(COLUMNS));
      send_word(OP_PUT, 8'h7F, 11'h7FF);
      scroll_from_last_row(0);
      scroll_from_last_row(1);
      scroll_from_last_row(2);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
            default: begin send_idle_pct = 38; recv_stall_pct = 38; end
         endcase
         target = words_sent + PHASE_WORDS;
         while (words_sent < target) random_sequence();
      end

      req_valid <= 1'b0;
      while (sb.pending_cursor_cells.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/tcw_pkg.sv
sv/tcw_cell_ram.sv
sv/tcw_ctrl.sv
sv/text_console_char_writer.sv
tb/tb_text_console_char_writer.sv
